@@ rtl/sync_xor_frame_receiver_unit_macros.svh @@
// Assertion macros for the sync XOR frame receiver.
`ifndef SYNC_XOR_FRAME_RECEIVER_UNIT_MACROS_SVH
`define SYNC_XOR_FRAME_RECEIVER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SXFR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SXFR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/sxfr_pkg.sv @@
// Shared types and constants of the sync XOR frame receiver.
`default_nettype none

package sxfr_pkg;

  // Header byte and the value a good check leaves behind.
  localparam logic [7:0] HEADER_BYTE = 8'hFF;
  localparam logic [7:0] ZERO_BYTE   = 8'h00;

  // Header hunt and body collection states of the front end.
  typedef enum logic [1:0] {
    ST_HUNT,
    ST_HDR1,
    ST_HDR2,
    ST_BODY
  } front_state_t;

  // Status of the frame queue as seen by both ends.
  typedef struct packed {
    logic full;
    logic empty;
    logic head_bank;
  } qstat_t;

endpackage

`default_nettype wire

@@ rtl/sxfr_rx_if.sv @@
// Handshake channel carrying received bytes.
`default_nettype none

interface sxfr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

@@ rtl/sxfr_out_if.sv @@
// Handshake channel carrying checked frame body bytes.
`default_nettype none

interface sxfr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic [3:0] byte_index;
  logic       last_byte;

  modport source (output valid, output frame_byte, output byte_index, output last_byte,
                  input ready);
  modport sink (input valid, input frame_byte, input byte_index, input last_byte,
                output ready);
endinterface

`default_nettype wire

@@ rtl/sxfr_front.sv @@
// Front end: header hunt, body write into the free bank and XOR check.
`default_nettype none

module sxfr_front #(
  parameter int BODY_LEN = 10,
  parameter int IDX_W    = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  sxfr_rx_if.sink               rx,
  input  wire logic             q_full,
  output logic                  push,
  output logic                  push_bank,
  output logic                  wr_en,
  output logic [IDX_W:0]        wr_addr,
  output logic [7:0]            wr_data
);
  import sxfr_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BODY_LEN - 1);

  front_state_t     state, state_next;
  logic [7:0]       acc, acc_next;
  logic [IDX_W-1:0] wr_idx, wr_idx_next;
  logic             bank, bank_next;
  logic             accept;
  logic [7:0]       b;
  logic [7:0]       acc_upd;

  // A word is taken whenever a bank is free to receive it.
  assign rx.ready = !q_full;
  assign accept   = rx.valid && rx.ready;
  assign b        = rx.rx_byte;
  assign acc_upd  = acc ^ b;

  // Body bytes land at the current index of the bank being filled.
  assign wr_addr   = {bank, wr_idx};
  assign wr_data   = b;
  assign push_bank = bank;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_HUNT;
      acc    <= ZERO_BYTE;
      wr_idx <= '0;
      bank   <= 1'b0;
    end else begin
      state  <= state_next;
      acc    <= acc_next;
      wr_idx <= wr_idx_next;
      bank   <= bank_next;
    end
  end

  // Next state, body writes and frame hand-off.
  always_comb begin
    state_next  = state;
    acc_next    = acc;
    wr_idx_next = wr_idx;
    bank_next   = bank;
    wr_en       = 1'b0;
    push        = 1'b0;
    if (accept) begin
      case (state)
        ST_HUNT: begin
          if (b == HEADER_BYTE) state_next = ST_HDR1;
        end
        ST_HDR1: begin
          if (b == HEADER_BYTE) begin
            state_next = ST_HDR2;
          end else begin
            // The second header byte is taken as missing; this word is body.
            wr_en       = 1'b1;
            acc_next    = acc_upd;
            wr_idx_next = wr_idx + 1'b1;
            state_next  = ST_BODY;
          end
        end
        ST_HDR2: begin
          // Padding after a full header is skipped.
          if (b != HEADER_BYTE) begin
            wr_en       = 1'b1;
            acc_next    = acc_upd;
            wr_idx_next = wr_idx + 1'b1;
            state_next  = ST_BODY;
          end
        end
        ST_BODY: begin
          wr_en = 1'b1;
          if (wr_idx == LAST_IDX) begin
            // Frame complete: hand a good one over, drop a bad one.
            state_next  = ST_HUNT;
            acc_next    = ZERO_BYTE;
            wr_idx_next = '0;
            if (acc_upd == ZERO_BYTE) begin
              push      = 1'b1;
              bank_next = ~bank;
            end
          end else begin
            acc_next    = acc_upd;
            wr_idx_next = wr_idx + 1'b1;
          end
        end
        default: begin
          state_next = ST_HUNT;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/sxfr_queue.sv @@
// Short queue of completed frames, each named by the bank that holds it.
`default_nettype none

module sxfr_queue (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  wire logic       push_bank,
  input  wire logic       pop,
  output sxfr_pkg::qstat_t stat
);
  import sxfr_pkg::*;

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic             slots [DEPTH];
  logic [PTR_W-1:0] wptr, rptr;
  logic [CNT_W-1:0] count;

  assign stat.full      = (count == CNT_W'(DEPTH));
  assign stat.empty     = (count == '0);
  assign stat.head_bank = slots[rptr];

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop)  rptr <= rptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  // Slot contents.
  always_ff @(posedge clk) begin
    if (push) slots[wptr] <= push_bank;
  end

endmodule

`default_nettype wire

@@ rtl/sxfr_back.sv @@
// Back end: two-bank body memory and read-out of checked frames.
`default_nettype none

module sxfr_back #(
  parameter int BODY_LEN = 10,
  parameter int IDX_W    = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire logic [IDX_W:0]   wr_addr,
  input  wire logic [7:0]       wr_data,
  input  wire sxfr_pkg::qstat_t qstat,
  output logic                  pop,
  sxfr_out_if.source            tx
);
  import sxfr_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BODY_LEN - 1);
  localparam int               MEM_DEPTH = 2 << IDX_W;

  logic [7:0]       mem [MEM_DEPTH];
  logic [7:0]       rd_data;
  logic [IDX_W-1:0] rd_idx;
  logic [IDX_W-1:0] out_idx;
  logic             out_last;
  logic             out_valid;
  logic             load;
  logic             at_last;
  logic [IDX_W+3:0] idx_ext;

  // Fetch the next word when a frame waits and the output is free.
  assign load    = !qstat.empty && (!out_valid || tx.ready);
  assign at_last = (rd_idx == LAST_IDX);
  assign pop     = load && at_last;

  // Body memory: one write port from the front, one read port here.
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (load) begin
      rd_data  <= mem[{qstat.head_bank, rd_idx}];
      out_idx  <= rd_idx;
      out_last <= at_last;
    end
  end

  // Read index and output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        rd_idx    <= at_last ? '0 : rd_idx + 1'b1;
        out_valid <= 1'b1;
      end else if (tx.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign idx_ext       = {4'b0000, out_idx};
  assign tx.valid      = out_valid;
  assign tx.frame_byte = rd_data;
  assign tx.byte_index = idx_ext[3:0];
  assign tx.last_byte  = out_last;

endmodule

`default_nettype wire

@@ rtl/sync_xor_frame_receiver_unit.sv @@
// The first body word of a good frame (FRAME_LENGTH-2 body words, held in one of two banks)
// is offered once the frame has entered the queue and that word has been read into the output
// register. Throughput: one received word per cycle while a body bank is free; words go out
// one per cycle while the output is ready. Input stalls only while both banks hold frames
// not yet read out. Reset is synchronous and clears the hunt state, check, queue and output;
// body memory is left as is, since every entry of a bank is written before that bank is read.
`default_nettype none

module sync_xor_frame_receiver_unit #(
  parameter int FRAME_LENGTH = 12
) (
  input  wire logic  clk,
  input  wire logic  rst,
  sxfr_rx_if.sink    rx,
  sxfr_out_if.source tx
);
  import sxfr_pkg::*;

  `include "sync_xor_frame_receiver_unit_macros.svh"

  localparam int BODY_LEN = FRAME_LENGTH - 2;
  localparam int IDX_W    = $clog2(BODY_LEN);

  qstat_t         q_stat;
  logic           push;
  logic           push_bank;
  logic           pop;
  logic           wr_en;
  logic [IDX_W:0] wr_addr;
  logic [7:0]     wr_data;

  // Header hunt and body capture.
  sxfr_front #(
    .BODY_LEN (BODY_LEN),
    .IDX_W    (IDX_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .rx        (rx),
    .q_full    (q_stat.full),
    .push      (push),
    .push_bank (push_bank),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  // Completed good frames waiting for read-out.
  sxfr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_bank (push_bank),
    .pop       (pop),
    .stat      (q_stat)
  );

  // Frame memory and output stage.
  sxfr_back #(
    .BODY_LEN (BODY_LEN),
    .IDX_W    (IDX_W)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .qstat   (q_stat),
    .pop     (pop),
    .tx      (tx)
  );

  // A frame is handed over only when a slot is free, and read out only when one is held.
  `SXFR_ASSERT_NOW(a_push_room, clk, rst, push, !q_stat.full, "frame pushed into a full queue")
  `SXFR_ASSERT_NOW(a_pop_held, clk, rst, pop, !q_stat.empty, "frame popped from an empty queue")
  // The bank being filled is never the one being read out.
  `SXFR_ASSERT_NOW(a_bank_apart, clk, rst, wr_en && !q_stat.empty,
                   wr_addr[IDX_W] != q_stat.head_bank, "write into the bank under read-out")
  // Words of one frame follow each other without a gap.
  `SXFR_ASSERT_NEXT(a_frame_dense, clk, rst, tx.valid && tx.ready && !tx.last_byte,
                    tx.valid, "gap inside an outgoing frame")

endmodule

`default_nettype wire

@@ tb/sv/sync_xor_frame_receiver_unit_tb.sv @@
// Self-checking bench for the sync XOR frame receiver: byte stream in, checked frame words out.
module sync_xor_frame_receiver_unit_tb;
  import sxfr_pkg::*;

  localparam int FRAME_LEN     = 12;
  localparam int BODY_LEN      = FRAME_LEN - 2;
  localparam int PRESSURE_HOLD = 400;
  localparam int STALL_LIMIT   = 2000;
  localparam int RANDOM_WORDS  = 220;
  localparam int CALM_WORDS    = 40;

  // One word of a frame body as it leaves the block.
  typedef struct packed {
    logic [7:0] frame_byte;
    logic [3:0] byte_index;
    logic       last_byte;
  } body_word_t;

  // One row of the opening script; a silent row must release no word at all.
  typedef struct packed {
    logic [7:0] word;
    bit         silent;
  } script_row_t;

  // Hunting noise, full header with padding, a good frame carrying 0x00 and 0xFF in its body,
  // then an assumed header opening a frame whose check does not cancel.
  localparam script_row_t OPENING [25] = '{
    '{8'h00, 1'b1}, '{8'hFF, 1'b1}, '{8'hFF, 1'b1}, '{8'hFF, 1'b1},
    '{8'h00, 1'b1}, '{8'hFF, 1'b1}, '{8'h01, 1'b1}, '{8'h80, 1'b1}, '{8'hFF, 1'b1},
    '{8'h55, 1'b1}, '{8'hAA, 1'b1}, '{8'h00, 1'b1}, '{8'hFF, 1'b1}, '{8'h81, 1'b0},
    '{8'hFF, 1'b1}, '{8'h12, 1'b1}, '{8'h34, 1'b1}, '{8'h56, 1'b1}, '{8'h78, 1'b1},
    '{8'h9A, 1'b1}, '{8'hBC, 1'b1}, '{8'hDE, 1'b1}, '{8'hF0, 1'b1}, '{8'h0F, 1'b1},
    '{8'h00, 1'b1}
  };

  logic clk = 1'b0;
  logic rst;

  sxfr_rx_if  rx_ch ();
  sxfr_out_if tx_ch ();

  sync_xor_frame_receiver_unit #(.FRAME_LENGTH(FRAME_LEN)) DUT (
    .clk(clk),
    .rst(rst),
    .rx (rx_ch),
    .tx (tx_ch)
  );

  // Free-running clock, period 10.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: bytes held in the current frame, running XOR and the stored body.
  logic [3:0]  held_count  = 4'd0;
  logic [7:0]  running_xor = ZERO_BYTE;
  logic [7:0]  body_copy [BODY_LEN];
  body_word_t  frames_due [$];

  int unsigned mismatches     = 0;
  int unsigned words_framed   = 0;
  int unsigned words_checked  = 0;
  int unsigned frames_passed  = 0;
  int unsigned frames_dropped = 0;
  int unsigned quiet_cycles   = 0;
  int          hold_left      = 0;
  bit          calm           = 1'b0;
  bit          pressure_req   = 1'b0;
  bit          pressure_done  = 1'b0;

  // A body byte is stored at its position and folded into the check.
  function automatic void take_body(input logic [7:0] b);
    body_copy[held_count - 4'd2] = b;
    running_xor ^= b;
    held_count++;
  endfunction

  // Advances the frame hunt by one received byte and queues any words a good frame releases.
  // The flag tells whether the byte was simply passed over by the hunt or the padding skip.
  function automatic void absorb_byte(input logic [7:0] b, output bit ignored);
    body_word_t w;
    ignored = 1'b0;
    if (held_count == 4'd0) begin
      if (b == HEADER_BYTE) held_count = 4'd1;
      else ignored = 1'b1;
    end else if (held_count == 4'd1) begin
      // A lone header byte followed by anything else stands for a full header.
      held_count = 4'd2;
      if (b != HEADER_BYTE) take_body(b);
    end else if (held_count == 4'd2 && b == HEADER_BYTE) begin
      ignored = 1'b1;
    end else begin
      take_body(b);
      if (held_count == FRAME_LEN) begin
        if (running_xor == ZERO_BYTE) begin
          for (int k = 0; k < BODY_LEN; k++) begin
            w.frame_byte = body_copy[k];
            w.byte_index = 4'(k);
            w.last_byte  = (k == BODY_LEN - 1);
            frames_due.push_back(w);
          end
          frames_passed++;
        end else begin
          frames_dropped++;
        end
        held_count  = 4'd0;
        running_xor = ZERO_BYTE;
      end
    end
  endfunction

  // Offers one byte, possibly after an idle burst, and predicts once it is taken.
  task automatic send_byte(input logic [7:0] b, input bit silent);
    int before_size;
    bit ignored;
    if (!calm && $urandom_range(0, 3) == 0) begin
      rx_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    do @(posedge clk); while (rx_ch.ready !== 1'b1);
    before_size = frames_due.size();
    absorb_byte(b, ignored);
    if (silent) begin
      while (frames_due.size() > before_size) void'(frames_due.pop_back());
    end
    if (!ignored) words_framed++;
  endtask

  // A frame with random header form and body; some get noise ahead, a bad check or a cut.
  task automatic send_random_frame();
    logic [7:0] body [BODY_LEN];
    logic [7:0] sum;
    int style;
    int cut;
    sum = ZERO_BYTE;
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 254)), 1'b0);
    end
    style = $urandom_range(0, 3);
    send_byte(HEADER_BYTE, 1'b0);
    if (style != 0) send_byte(HEADER_BYTE, 1'b0);
    if (style == 3) repeat ($urandom_range(1, 3)) send_byte(HEADER_BYTE, 1'b0);
    for (int k = 0; k < BODY_LEN - 1; k++) begin
      if (k == 0) body[k] = 8'($urandom_range(0, 254));
      else if ($urandom_range(0, 7) == 0) body[k] = HEADER_BYTE;
      else body[k] = 8'($urandom);
      sum ^= body[k];
    end
    body[BODY_LEN - 1] = sum;
    if ($urandom_range(0, 3) == 0) body[BODY_LEN - 1] ^= 8'($urandom_range(1, 255));
    cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, BODY_LEN - 1) : BODY_LEN;
    for (int k = 0; k < cut; k++) send_byte(body[k], 1'b0);
  endtask

  // Output side: checks each accepted word against the oldest expectation and paces ready.
  always @(posedge clk) begin : drain
    body_word_t want;
    if (!rst && tx_ch.valid === 1'b1 && tx_ch.ready === 1'b1) begin
      if (frames_due.size() == 0) begin
        $display("%0t: unexpected word: expected none, got byte %h index %0d last %b",
                 $time, tx_ch.frame_byte, tx_ch.byte_index, tx_ch.last_byte);
        mismatches++;
      end else begin
        want = frames_due.pop_front();
        words_checked++;
        if (tx_ch.frame_byte !== want.frame_byte) begin
          $display("%0t: frame_byte mismatch: expected %h, got %h",
                   $time, want.frame_byte, tx_ch.frame_byte);
          mismatches++;
        end
        if (tx_ch.byte_index !== want.byte_index) begin
          $display("%0t: byte_index mismatch: expected %0d, got %0d",
                   $time, want.byte_index, tx_ch.byte_index);
          mismatches++;
        end
        if (tx_ch.last_byte !== want.last_byte) begin
          $display("%0t: last_byte mismatch: expected %b, got %b",
                   $time, want.last_byte, tx_ch.last_byte);
          mismatches++;
        end
      end
    end
    // One long hold-off lets both frame banks fill so that the input has to stall.
    if (rst) begin
      tx_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      tx_ch.ready <= 1'b0;
      hold_left--;
    end else if (pressure_req && !pressure_done) begin
      pressure_done = 1'b1;
      hold_left     = PRESSURE_HOLD - 1;
      tx_ch.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      hold_left = $urandom_range(1, 12) - 1;
      tx_ch.ready <= 1'b0;
    end else begin
      tx_ch.ready <= 1'b1;
    end
  end

  // Watchdog: too long without a word moving on either side ends the run.
  always @(posedge clk) begin
    if ((rx_ch.valid === 1'b1 && rx_ch.ready === 1'b1) ||
        (tx_ch.valid === 1'b1 && tx_ch.ready === 1'b1)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no word moved for %0d cycles, %0d words still due",
               $time, STALL_LIMIT, frames_due.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Stimulus: reset, the opening script, then random frames ending in a calm stretch.
  initial begin
    int random_goal;
    rst           = 1'b1;
    rx_ch.valid   = 1'b0;
    rx_ch.rx_byte = 8'h00;
    tx_ch.ready   = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (OPENING[i]) send_byte(OPENING[i].word, OPENING[i].silent);

    pressure_req = 1'b1;
    random_goal  = words_framed + RANDOM_WORDS;
    while (words_framed < random_goal) begin
      calm = (words_framed + CALM_WORDS > random_goal);
      send_random_frame();
    end
    rx_ch.valid <= 1'b0;

    // Drain what is still owed, then give any stray word time to show up.
    while (frames_due.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("Fed %0d framing bytes; %0d good frames gave %0d checked words, %0d frames dropped.",
             words_framed, frames_passed, words_checked, frames_dropped);
    $display("Covered assumed and padded headers, cut frames, noise and a full output stall.");
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
